### sv/aarm_pkg.sv
// Shared constants and the CORDIC arctangent table for the axis-angle rotation block.
package aarm_pkg;

    localparam int IN_W     = 16;
    localparam int OUT_W    = 16;
    localparam int NUM_AX   = 3;
    localparam int NUM_ENT  = 9;

    // CORDIC datapath width: Q30 values plus growth and sign.
    localparam int CW       = 34;
    // Digit-by-digit square root of a 62-bit radicand: one result bit per step.
    localparam int SQ_STEPS = 31;
    localparam int SQ_RAD_W = 62;
    localparam int SQ_REM_W = 33;
    localparam int N2_W     = 32;
    localparam int MAG_W    = 16;
    localparam int R_W      = 31;

    localparam logic signed [CW-1:0] CORDIC_X0  = 34'sd652032874;
    localparam logic signed [CW-1:0] QTR_TURN   = 34'sd1073741824;
    localparam logic signed [CW-1:0] HALF_TURN  = 34'sd2147483648;

    // Arctangent of 2^-i in 2^32-per-turn units.
    localparam logic [31:0] ATAN_TAB [32] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
        32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
        32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
        32'h00028BE6, 32'h000145F3, 32'h0000A2F9, 32'h0000517D,
        32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
        32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
        32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005,
        32'h00000003, 32'h00000001, 32'h00000001, 32'h00000000
    };

endpackage

### sv/aarm_front.sv
// Front stages: axis magnitudes, squared norm and angle folding.
module aarm_front (
    input  logic                                   aclk,
    input  logic                                   en,
    input  logic signed [aarm_pkg::IN_W-1:0]       in_x,
    input  logic signed [aarm_pkg::IN_W-1:0]       in_y,
    input  logic signed [aarm_pkg::IN_W-1:0]       in_z,
    input  logic        [aarm_pkg::IN_W-1:0]       in_phase,
    output logic        [aarm_pkg::N2_W-1:0]       n2,
    output logic        [aarm_pkg::MAG_W-1:0]      mag [aarm_pkg::NUM_AX],
    output logic                                   sgn [aarm_pkg::NUM_AX],
    output logic                                   zero,
    output logic signed [aarm_pkg::CW-1:0]         p,
    output logic                                   pneg
);
    import aarm_pkg::*;

    logic signed [IN_W-1:0]  ax [NUM_AX];
    logic [MAG_W-1:0]        mag_next [NUM_AX];
    logic [N2_W-1:0]         sq_next [NUM_AX];
    logic signed [31:0]      p32;
    logic signed [CW-1:0]    pe;
    logic signed [CW-1:0]    p_next;
    logic                    pneg_next;

    logic [N2_W-1:0]         sq_reg [NUM_AX];
    logic [MAG_W-1:0]        mag1_reg [NUM_AX];
    logic                    sgn1_reg [NUM_AX];
    logic                    zero1_reg;
    logic signed [CW-1:0]    p1_reg;
    logic                    pneg1_reg;

    logic [N2_W-1:0]         n2_reg;
    logic [MAG_W-1:0]        mag2_reg [NUM_AX];
    logic                    sgn2_reg [NUM_AX];
    logic                    zero2_reg;
    logic signed [CW-1:0]    p2_reg;
    logic                    pneg2_reg;

    assign ax[0] = in_x;
    assign ax[1] = in_y;
    assign ax[2] = in_z;

    always_comb begin
        for (int i = 0; i < NUM_AX; i++) begin
            mag_next[i] = ax[i][IN_W-1] ? MAG_W'(-ax[i]) : MAG_W'(ax[i]);
            sq_next[i]  = N2_W'(mag_next[i]) * N2_W'(mag_next[i]);
        end
    end

    // The phase is a signed turn fraction; fold it into the CORDIC range.
    always_comb begin
        p32       = {in_phase, 16'h0000};
        pe        = CW'(p32);
        p_next    = pe;
        pneg_next = 1'b0;
        if (pe > QTR_TURN) begin
            p_next    = pe - HALF_TURN;
            pneg_next = 1'b1;
        end else if (pe < -QTR_TURN) begin
            p_next    = pe + HALF_TURN;
            pneg_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < NUM_AX; i++) begin
                sq_reg[i]   <= sq_next[i];
                mag1_reg[i] <= mag_next[i];
                sgn1_reg[i] <= ax[i][IN_W-1];
                mag2_reg[i] <= mag1_reg[i];
                sgn2_reg[i] <= sgn1_reg[i];
            end
            zero1_reg <= (in_x == '0) && (in_y == '0) && (in_z == '0);
            p1_reg    <= p_next;
            pneg1_reg <= pneg_next;
            n2_reg    <= sq_reg[0] + sq_reg[1] + sq_reg[2];
            zero2_reg <= zero1_reg;
            p2_reg    <= p1_reg;
            pneg2_reg <= pneg1_reg;
        end
    end

    assign n2   = n2_reg;
    assign mag  = mag2_reg;
    assign sgn  = sgn2_reg;
    assign zero = zero2_reg;
    assign p    = p2_reg;
    assign pneg = pneg2_reg;

endmodule

### sv/aarm_sqcord.sv
// Pipelined square root of the scaled norm running beside the CORDIC sine/cosine stages.
module aarm_sqcord #(
    parameter int CORDIC_STAGES = 16
) (
    input  logic                                   aclk,
    input  logic                                   en,
    input  logic        [aarm_pkg::N2_W-1:0]       n2,
    input  logic        [aarm_pkg::MAG_W-1:0]      mag_i [aarm_pkg::NUM_AX],
    input  logic                                   sgn_i [aarm_pkg::NUM_AX],
    input  logic                                   zero_i,
    input  logic signed [aarm_pkg::CW-1:0]         p,
    input  logic                                   pneg_i,
    output logic        [aarm_pkg::R_W-1:0]        r,
    output logic        [aarm_pkg::MAG_W-1:0]      mag_o [aarm_pkg::NUM_AX],
    output logic                                   sgn_o [aarm_pkg::NUM_AX],
    output logic                                   zero_o,
    output logic signed [aarm_pkg::CW-1:0]         cx,
    output logic signed [aarm_pkg::CW-1:0]         cy,
    output logic                                   pneg_o
);
    import aarm_pkg::*;

    localparam int NS = (CORDIC_STAGES > SQ_STEPS) ? CORDIC_STAGES : SQ_STEPS;

    logic [SQ_REM_W-1:0]     rem_in [NS];
    logic [R_W-1:0]          res_in [NS];
    logic [SQ_RAD_W-1:0]     nsh_in [NS];
    logic signed [CW-1:0]    cx_in  [NS];
    logic signed [CW-1:0]    cy_in  [NS];
    logic signed [CW-1:0]    cz_in  [NS];
    logic [MAG_W-1:0]        mag_in [NS][NUM_AX];
    logic                    sgn_in [NS][NUM_AX];
    logic                    zero_in [NS];
    logic                    pneg_in [NS];

    logic [SQ_REM_W-1:0]     rem_reg [NS];
    logic [R_W-1:0]          res_reg [NS];
    logic [SQ_RAD_W-1:0]     nsh_reg [NS];
    logic signed [CW-1:0]    cx_reg  [NS];
    logic signed [CW-1:0]    cy_reg  [NS];
    logic signed [CW-1:0]    cz_reg  [NS];
    logic [MAG_W-1:0]        mag_reg [NS][NUM_AX];
    logic                    sgn_reg [NS][NUM_AX];
    logic                    zero_reg [NS];
    logic                    pneg_reg [NS];

    for (genvar k = 0; k < NS; k++) begin : g_stage
        logic [SQ_REM_W-1:0]  rem_next;
        logic [R_W-1:0]       res_next;
        logic [SQ_RAD_W-1:0]  nsh_next;
        logic signed [CW-1:0] cx_next;
        logic signed [CW-1:0] cy_next;
        logic signed [CW-1:0] cz_next;

        if (k == 0) begin : g_first
            assign rem_in[k]  = '0;
            assign res_in[k]  = '0;
            assign nsh_in[k]  = {n2, 30'h0};
            assign cx_in[k]   = CORDIC_X0;
            assign cy_in[k]   = '0;
            assign cz_in[k]   = p;
            assign mag_in[k]  = mag_i;
            assign sgn_in[k]  = sgn_i;
            assign zero_in[k] = zero_i;
            assign pneg_in[k] = pneg_i;
        end else begin : g_rest
            assign rem_in[k]  = rem_reg[k-1];
            assign res_in[k]  = res_reg[k-1];
            assign nsh_in[k]  = nsh_reg[k-1];
            assign cx_in[k]   = cx_reg[k-1];
            assign cy_in[k]   = cy_reg[k-1];
            assign cz_in[k]   = cz_reg[k-1];
            assign mag_in[k]  = mag_reg[k-1];
            assign sgn_in[k]  = sgn_reg[k-1];
            assign zero_in[k] = zero_reg[k-1];
            assign pneg_in[k] = pneg_reg[k-1];
        end

        if (k < SQ_STEPS) begin : g_sqrt
            logic [SQ_REM_W+1:0] rem_sh;
            logic [SQ_REM_W+1:0] trial;
            logic                ge;
            always_comb begin
                rem_sh   = {rem_in[k], nsh_in[k][SQ_RAD_W-1 -: 2]};
                trial    = {2'b00, res_in[k], 2'b01};
                ge       = rem_sh >= trial;
                rem_next = ge ? SQ_REM_W'(rem_sh - trial) : rem_sh[SQ_REM_W-1:0];
                res_next = {res_in[k][R_W-2:0], ge};
                nsh_next = {nsh_in[k][SQ_RAD_W-3:0], 2'b00};
            end
        end else begin : g_sqrt_hold
            assign rem_next = rem_in[k];
            assign res_next = res_in[k];
            assign nsh_next = nsh_in[k];
        end

        if (k < CORDIC_STAGES) begin : g_cordic
            logic signed [CW-1:0] dx;
            logic signed [CW-1:0] dy;
            logic signed [CW-1:0] at;
            always_comb begin
                dx = cy_in[k] >>> k;
                dy = cx_in[k] >>> k;
                at = CW'(ATAN_TAB[k]);
                if (!cz_in[k][CW-1]) begin
                    cx_next = cx_in[k] - dx;
                    cy_next = cy_in[k] + dy;
                    cz_next = cz_in[k] - at;
                end else begin
                    cx_next = cx_in[k] + dx;
                    cy_next = cy_in[k] - dy;
                    cz_next = cz_in[k] + at;
                end
            end
        end else begin : g_cordic_hold
            assign cx_next = cx_in[k];
            assign cy_next = cy_in[k];
            assign cz_next = cz_in[k];
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg[k]  <= rem_next;
                res_reg[k]  <= res_next;
                nsh_reg[k]  <= nsh_next;
                cx_reg[k]   <= cx_next;
                cy_reg[k]   <= cy_next;
                cz_reg[k]   <= cz_next;
                mag_reg[k]  <= mag_in[k];
                sgn_reg[k]  <= sgn_in[k];
                zero_reg[k] <= zero_in[k];
                pneg_reg[k] <= pneg_in[k];
            end
        end
    end

    assign r      = res_reg[NS-1];
    assign mag_o  = mag_reg[NS-1];
    assign sgn_o  = sgn_reg[NS-1];
    assign zero_o = zero_reg[NS-1];
    assign cx     = cx_reg[NS-1];
    assign cy     = cy_reg[NS-1];
    assign pneg_o = pneg_reg[NS-1];

endmodule

### sv/aarm_div.sv
// Restoring divider lanes that scale each axis component by the norm, one quotient bit per stage.
module aarm_div #(
    parameter int FRAC_BITS = 14
) (
    input  logic                                   aclk,
    input  logic                                   en,
    input  logic        [aarm_pkg::R_W-1:0]        r,
    input  logic        [aarm_pkg::MAG_W-1:0]      mag [aarm_pkg::NUM_AX],
    input  logic                                   sgn [aarm_pkg::NUM_AX],
    input  logic                                   zero_i,
    input  logic signed [aarm_pkg::CW-1:0]         cx_i,
    input  logic signed [aarm_pkg::CW-1:0]         cy_i,
    input  logic                                   pneg_i,
    output logic signed [FRAC_BITS+1:0]            u [aarm_pkg::NUM_AX],
    output logic                                   zero_o,
    output logic signed [aarm_pkg::CW-1:0]         cx_o,
    output logic signed [aarm_pkg::CW-1:0]         cy_o,
    output logic                                   pneg_o
);
    import aarm_pkg::*;

    localparam int QB = FRAC_BITS + 2;
    localparam int NW = FRAC_BITS + 32;
    localparam int RW = R_W;
    localparam int XW = FRAC_BITS + 2;
    localparam logic [QB-1:0] ONE_Q = QB'(1) << FRAC_BITS;

    // Stage 0 forms the rounded numerator; stages 1..QB each produce one quotient bit.
    logic [RW-1:0]           rem_reg [QB+1][NUM_AX];
    logic [QB-1:0]           lo_reg  [QB+1][NUM_AX];
    logic [QB-1:0]           q_reg   [QB+1][NUM_AX];
    logic                    sgn_reg [QB+1][NUM_AX];
    logic [R_W-1:0]          r_reg   [QB+1];
    logic                    zero_reg [QB+1];
    logic signed [CW-1:0]    cx_reg  [QB+1];
    logic signed [CW-1:0]    cy_reg  [QB+1];
    logic                    pneg_reg [QB+1];

    logic signed [XW-1:0]    u_reg [NUM_AX];
    logic                    zero_f_reg;
    logic signed [CW-1:0]    cx_f_reg;
    logic signed [CW-1:0]    cy_f_reg;
    logic                    pneg_f_reg;

    logic [NW-1:0]           num [NUM_AX];

    always_comb begin
        for (int i = 0; i < NUM_AX; i++) begin
            num[i] = (NW'(mag[i]) << (FRAC_BITS + 15)) + NW'(r >> 1);
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < NUM_AX; i++) begin
                rem_reg[0][i] <= RW'(num[i] >> QB);
                lo_reg[0][i]  <= num[i][QB-1:0];
                q_reg[0][i]   <= '0;
                sgn_reg[0][i] <= sgn[i];
            end
            r_reg[0]    <= r;
            zero_reg[0] <= zero_i;
            cx_reg[0]   <= cx_i;
            cy_reg[0]   <= cy_i;
            pneg_reg[0] <= pneg_i;
        end
    end

    for (genvar j = 1; j <= QB; j++) begin : g_step
        logic [RW:0]    rsh [NUM_AX];
        logic           ge  [NUM_AX];
        logic [RW-1:0]  rem_next [NUM_AX];

        always_comb begin
            for (int i = 0; i < NUM_AX; i++) begin
                rsh[i]      = {rem_reg[j-1][i], lo_reg[j-1][i][QB-1]};
                ge[i]       = rsh[i] >= {1'b0, r_reg[j-1]};
                rem_next[i] = ge[i] ? RW'(rsh[i] - {1'b0, r_reg[j-1]}) : rsh[i][RW-1:0];
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                for (int i = 0; i < NUM_AX; i++) begin
                    rem_reg[j][i] <= rem_next[i];
                    lo_reg[j][i]  <= {lo_reg[j-1][i][QB-2:0], 1'b0};
                    q_reg[j][i]   <= {q_reg[j-1][i][QB-2:0], ge[i]};
                    sgn_reg[j][i] <= sgn_reg[j-1][i];
                end
                r_reg[j]    <= r_reg[j-1];
                zero_reg[j] <= zero_reg[j-1];
                cx_reg[j]   <= cx_reg[j-1];
                cy_reg[j]   <= cy_reg[j-1];
                pneg_reg[j] <= pneg_reg[j-1];
            end
        end
    end

    // Clamp to one and apply the component sign.
    logic [QB-1:0]        qc [NUM_AX];
    logic signed [XW-1:0] uq [NUM_AX];

    always_comb begin
        for (int i = 0; i < NUM_AX; i++) begin
            qc[i] = (q_reg[QB][i] > ONE_Q) ? ONE_Q : q_reg[QB][i];
            uq[i] = XW'(qc[i]);
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < NUM_AX; i++) begin
                u_reg[i] <= sgn_reg[QB][i] ? -uq[i] : uq[i];
            end
            zero_f_reg <= zero_reg[QB];
            cx_f_reg   <= cx_reg[QB];
            cy_f_reg   <= cy_reg[QB];
            pneg_f_reg <= pneg_reg[QB];
        end
    end

    assign u      = u_reg;
    assign zero_o = zero_f_reg;
    assign cx_o   = cx_f_reg;
    assign cy_o   = cy_f_reg;
    assign pneg_o = pneg_f_reg;

endmodule

### sv/aarm_matrix.sv
// Rodrigues products, sums and saturation, four register stages.
module aarm_matrix #(
    parameter int FRAC_BITS = 14
) (
    input  logic                                   aclk,
    input  logic                                   en,
    input  logic signed [FRAC_BITS+1:0]            u [aarm_pkg::NUM_AX],
    input  logic                                   zero_i,
    input  logic signed [aarm_pkg::CW-1:0]         cx,
    input  logic signed [aarm_pkg::CW-1:0]         cy,
    input  logic                                   pneg,
    output logic signed [aarm_pkg::OUT_W-1:0]      ent [aarm_pkg::NUM_ENT],
    output logic                                   zero_o
);
    import aarm_pkg::*;

    localparam int XW  = FRAC_BITS + 2;
    localparam int SW  = FRAC_BITS + 3;
    localparam int TW  = FRAC_BITS + 4;
    localparam int EW  = FRAC_BITS + 5;
    localparam int PW  = 2 * XW;
    localparam int SPW = XW + SW;
    localparam int TPW = XW + TW;
    localparam int SH  = 30 - FRAC_BITS;

    localparam logic signed [CW-1:0]  C_HALF  = CW'((64'd1 << SH) >> 1);
    localparam logic signed [PW-1:0]  P_HALF  = PW'(64'd1 << (FRAC_BITS - 1));
    localparam logic signed [SPW-1:0] SP_HALF = SPW'(64'd1 << (FRAC_BITS - 1));
    localparam logic signed [TPW-1:0] TP_HALF = TPW'(64'd1 << (FRAC_BITS - 1));
    localparam logic signed [TW-1:0]  ONE_T   = TW'(64'd1 << FRAC_BITS);
    localparam logic signed [EW-1:0]  ONE_E   = EW'(64'd1 << FRAC_BITS);

    // Product order: xx, yy, zz, xy, xz, yz; sine products: xs, ys, zs.
    localparam int P_XX = 0, P_YY = 1, P_ZZ = 2, P_XY = 3, P_XZ = 4, P_YZ = 5;
    localparam int S_X = 0, S_Y = 1, S_Z = 2;

    // Stage 1
    logic signed [CW-1:0]  cn;
    logic signed [CW-1:0]  sn;
    logic signed [CW-1:0]  cr;
    logic signed [CW-1:0]  sr;
    logic signed [SW-1:0]  c1_reg;
    logic signed [SW-1:0]  s1_reg;
    logic signed [PW-1:0]  pp_reg [6];
    logic signed [XW-1:0]  u1_reg [NUM_AX];
    logic                  z1_reg;

    always_comb begin
        cn = pneg ? -cx : cx;
        sn = pneg ? -cy : cy;
        cr = (cn + C_HALF) >>> SH;
        sr = (sn + C_HALF) >>> SH;
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            c1_reg       <= SW'(cr);
            s1_reg       <= SW'(sr);
            pp_reg[P_XX] <= u[0] * u[0];
            pp_reg[P_YY] <= u[1] * u[1];
            pp_reg[P_ZZ] <= u[2] * u[2];
            pp_reg[P_XY] <= u[0] * u[1];
            pp_reg[P_XZ] <= u[0] * u[2];
            pp_reg[P_YZ] <= u[1] * u[2];
            u1_reg       <= u;
            z1_reg       <= zero_i;
        end
    end

    // Stage 2
    logic signed [PW-1:0]  pr [6];
    logic signed [XW-1:0]  q2_reg [6];
    logic signed [TW-1:0]  t2_reg;
    logic signed [SW-1:0]  c2_reg;
    logic signed [SPW-1:0] sp_reg [NUM_AX];
    logic                  z2_reg;

    always_comb begin
        for (int i = 0; i < 6; i++) begin
            pr[i] = (pp_reg[i] + P_HALF) >>> FRAC_BITS;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < 6; i++) begin
                q2_reg[i] <= XW'(pr[i]);
            end
            for (int i = 0; i < NUM_AX; i++) begin
                sp_reg[i] <= u1_reg[i] * s1_reg;
            end
            t2_reg <= ONE_T - TW'(c1_reg);
            c2_reg <= c1_reg;
            z2_reg <= z1_reg;
        end
    end

    // Stage 3
    logic signed [SPW-1:0] spr [NUM_AX];
    logic signed [TPW-1:0] tp_reg [6];
    logic signed [XW-1:0]  sq_reg [NUM_AX];
    logic signed [SW-1:0]  c3_reg;
    logic                  z3_reg;

    always_comb begin
        for (int i = 0; i < NUM_AX; i++) begin
            spr[i] = (sp_reg[i] + SP_HALF) >>> FRAC_BITS;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < 6; i++) begin
                tp_reg[i] <= q2_reg[i] * t2_reg;
            end
            for (int i = 0; i < NUM_AX; i++) begin
                sq_reg[i] <= XW'(spr[i]);
            end
            c3_reg <= c2_reg;
            z3_reg <= z2_reg;
        end
    end

    // Stage 4: round, sum, saturate.
    logic signed [TPW-1:0] tpr [6];
    logic signed [EW-1:0]  rt  [6];
    logic signed [EW-1:0]  se  [NUM_AX];
    logic signed [EW-1:0]  ce;
    logic signed [EW-1:0]  sum [NUM_ENT];
    logic signed [EW-1:0]  sat [NUM_ENT];
    logic signed [OUT_W-1:0] ent_next [NUM_ENT];
    logic signed [OUT_W-1:0] ent_reg  [NUM_ENT];
    logic                    z4_reg;

    always_comb begin
        for (int i = 0; i < 6; i++) begin
            tpr[i] = (tp_reg[i] + TP_HALF) >>> FRAC_BITS;
            rt[i]  = EW'(tpr[i]);
        end
        for (int i = 0; i < NUM_AX; i++) begin
            se[i] = EW'(sq_reg[i]);
        end
        ce = EW'(c3_reg);
        sum[0] = ce + rt[P_XX];
        sum[1] = rt[P_XY] - se[S_Z];
        sum[2] = rt[P_XZ] + se[S_Y];
        sum[3] = rt[P_XY] + se[S_Z];
        sum[4] = ce + rt[P_YY];
        sum[5] = rt[P_YZ] - se[S_X];
        sum[6] = rt[P_XZ] - se[S_Y];
        sum[7] = rt[P_YZ] + se[S_X];
        sum[8] = ce + rt[P_ZZ];
        for (int k = 0; k < NUM_ENT; k++) begin
            if (sum[k] > ONE_E) begin
                sat[k] = ONE_E;
            end else if (sum[k] < -ONE_E) begin
                sat[k] = -ONE_E;
            end else begin
                sat[k] = sum[k];
            end
            // A zero axis gives the identity matrix.
            if (z3_reg) begin
                sat[k] = (k % 4 == 0) ? ONE_E : '0;
            end
            ent_next[k] = sat[k][OUT_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            ent_reg <= ent_next;
            z4_reg  <= z3_reg;
        end
    end

    assign ent    = ent_reg;
    assign zero_o = z4_reg;

endmodule

### sv/axis_angle_rotation_matrix.sv
// Axis-angle to 3x3 rotation matrix, fully pipelined top level.
//
//  channel   direction  handshake          payload
//  s_        in         s_valid/s_ready    axis x/y/z, angle phase
//  m_        out        m_valid/m_ready    nine Q2.14 entries, zero_axis flag
//
// One word is accepted per cycle while the output is not stalled. The pipeline
// depth is set by the 31 square-root steps and the FRAC_BITS + 2 divider steps
// along with the front and matrix stages. The whole pipeline advances when
// the output register is empty or is being taken, so a stall freezes every stage.
// Reset clears only the valid bits.
module axis_angle_rotation_matrix #(
    parameter int FRAC_BITS     = 14,
    parameter int CORDIC_STAGES = 16
) (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   s_valid,
    output logic                                   s_ready,
    input  logic signed [aarm_pkg::IN_W-1:0]       s_axis_x,
    input  logic signed [aarm_pkg::IN_W-1:0]       s_axis_y,
    input  logic signed [aarm_pkg::IN_W-1:0]       s_axis_z,
    input  logic        [aarm_pkg::IN_W-1:0]       s_angle_phase,
    output logic                                   m_valid,
    input  logic                                   m_ready,
    output logic signed [aarm_pkg::OUT_W-1:0]      m_col0_row0,
    output logic signed [aarm_pkg::OUT_W-1:0]      m_col0_row1,
    output logic signed [aarm_pkg::OUT_W-1:0]      m_col0_row2,
    output logic signed [aarm_pkg::OUT_W-1:0]      m_col1_row0,
    output logic signed [aarm_pkg::OUT_W-1:0]      m_col1_row1,
    output logic signed [aarm_pkg::OUT_W-1:0]      m_col1_row2,
    output logic signed [aarm_pkg::OUT_W-1:0]      m_col2_row0,
    output logic signed [aarm_pkg::OUT_W-1:0]      m_col2_row1,
    output logic signed [aarm_pkg::OUT_W-1:0]      m_col2_row2,
    output logic                                   m_zero_axis
);
    import aarm_pkg::*;

    localparam int NS  = (CORDIC_STAGES > SQ_STEPS) ? CORDIC_STAGES : SQ_STEPS;
    localparam int LAT = 2 + NS + (FRAC_BITS + 4) + 4;
    localparam logic [OUT_W-1:0] ONE_OUT = OUT_W'(64'd1 << FRAC_BITS);

    logic                 en;
    logic                 valid_reg  [LAT];
    logic                 valid_next [LAT];

    logic [N2_W-1:0]      f_n2;
    logic [MAG_W-1:0]     f_mag [NUM_AX];
    logic                 f_sgn [NUM_AX];
    logic                 f_zero;
    logic signed [CW-1:0] f_p;
    logic                 f_pneg;

    logic [R_W-1:0]       q_r;
    logic [MAG_W-1:0]     q_mag [NUM_AX];
    logic                 q_sgn [NUM_AX];
    logic                 q_zero;
    logic signed [CW-1:0] q_cx;
    logic signed [CW-1:0] q_cy;
    logic                 q_pneg;

    logic signed [FRAC_BITS+1:0] d_u [NUM_AX];
    logic                 d_zero;
    logic signed [CW-1:0] d_cx;
    logic signed [CW-1:0] d_cy;
    logic                 d_pneg;

    logic signed [OUT_W-1:0] ent [NUM_ENT];

    assign en      = !valid_reg[LAT-1] || m_ready;
    assign s_ready = en;
    assign m_valid = valid_reg[LAT-1];

    always_comb begin
        for (int k = 0; k < LAT; k++) begin
            if (en) begin
                valid_next[k] = (k == 0) ? s_valid : valid_reg[(k == 0) ? 0 : k - 1];
            end else begin
                valid_next[k] = valid_reg[k];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k < LAT; k++) begin
                valid_reg[k] <= 1'b0;
            end
        end else begin
            valid_reg <= valid_next;
        end
    end

    aarm_front u_front (
        .aclk     (aclk),
        .en       (en),
        .in_x     (s_axis_x),
        .in_y     (s_axis_y),
        .in_z     (s_axis_z),
        .in_phase (s_angle_phase),
        .n2       (f_n2),
        .mag      (f_mag),
        .sgn      (f_sgn),
        .zero     (f_zero),
        .p        (f_p),
        .pneg     (f_pneg)
    );

    aarm_sqcord #(
        .CORDIC_STAGES (CORDIC_STAGES)
    ) u_sqcord (
        .aclk   (aclk),
        .en     (en),
        .n2     (f_n2),
        .mag_i  (f_mag),
        .sgn_i  (f_sgn),
        .zero_i (f_zero),
        .p      (f_p),
        .pneg_i (f_pneg),
        .r      (q_r),
        .mag_o  (q_mag),
        .sgn_o  (q_sgn),
        .zero_o (q_zero),
        .cx     (q_cx),
        .cy     (q_cy),
        .pneg_o (q_pneg)
    );

    aarm_div #(
        .FRAC_BITS (FRAC_BITS)
    ) u_div (
        .aclk   (aclk),
        .en     (en),
        .r      (q_r),
        .mag    (q_mag),
        .sgn    (q_sgn),
        .zero_i (q_zero),
        .cx_i   (q_cx),
        .cy_i   (q_cy),
        .pneg_i (q_pneg),
        .u      (d_u),
        .zero_o (d_zero),
        .cx_o   (d_cx),
        .cy_o   (d_cy),
        .pneg_o (d_pneg)
    );

    aarm_matrix #(
        .FRAC_BITS (FRAC_BITS)
    ) u_matrix (
        .aclk   (aclk),
        .en     (en),
        .u      (d_u),
        .zero_i (d_zero),
        .cx     (d_cx),
        .cy     (d_cy),
        .pneg   (d_pneg),
        .ent    (ent),
        .zero_o (m_zero_axis)
    );

    assign m_col0_row0 = ent[0];
    assign m_col0_row1 = ent[1];
    assign m_col0_row2 = ent[2];
    assign m_col1_row0 = ent[3];
    assign m_col1_row1 = ent[4];
    assign m_col1_row2 = ent[5];
    assign m_col2_row0 = ent[6];
    assign m_col2_row1 = ent[7];
    assign m_col2_row2 = ent[8];

    // A held output word must freeze the whole pipeline.
    a_stall_blocks_input: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |-> !s_ready)
        else $error("input taken while output word is stalled");

    // An accepted word enters the first valid slot.
    a_accept_tracked: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> valid_reg[0])
        else $error("accepted word lost at pipeline entry");

    // A zero axis must give the identity matrix; the diagonal and three off-diagonal entries are checked.
    a_zero_identity: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_zero_axis) |-> (m_col0_row0 == ONE_OUT && m_col1_row1 == ONE_OUT
            && m_col2_row2 == ONE_OUT && m_col0_row1 == '0 && m_col1_row2 == '0
            && m_col2_row0 == '0))
        else $error("zero axis did not give identity");

endmodule
